// File: design/iec_pkg.sv
// Package with the constants, types and character classes of the infix expression checker.
package iec_pkg;

  localparam int DEPTH_BITS = 16;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    BR_OK       = 2'd0,
    BR_EARLY    = 2'd1,
    BR_MISMATCH = 2'd2,
    BR_OVERFLOW = 2'd3
  } bracket_code_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_OTHER = 2'd1,
    KIND_OP    = 2'd2,
    KIND_OPEN  = 2'd3
  } kind_t;

  typedef logic [DEPTH_BITS-1:0] depth_t;

  function automatic logic char_is_op(input logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  endfunction

  function automatic logic char_is_valid(input logic [7:0] c);
    return char_is_op(c) || (c inside {[CH_ZERO:CH_NINE], CH_OPEN, CH_CLOSE});
  endfunction

endpackage

// File: design/infix_expression_checker.sv
// Top level of the infix expression checker: input stage, check logic and result register.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     ch, last
//   result    out        out_valid / out_stall   bracket_status, operator_status, char_status
//   config    in         cfg_write               cfg_data (ignore_spaces)
//
// One character is taken every cycle unless stalled; a final character passes through the
// input register, then the result register sets the result valid. The input register is
// the only wait point: it stalls only when it holds a final character and the result
// register still holds a stalled result. Reset clears the expression state, the input
// stage and the result valid; after reset ignore_spaces is zero and a new expression begins.
module infix_expression_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] bracket_status,
  output logic       operator_status,
  output logic       char_status,
  input  logic       cfg_write,
  input  logic       cfg_data
);
  import iec_pkg::*;

  logic          ignore_spaces;
  logic          s_valid;
  logic          s_valid_next;
  logic [7:0]    s_ch;
  logic          s_last;
  logic          s_go;

  depth_t        depth;
  depth_t        depth_next;
  bracket_code_t bracket_error;
  bracket_code_t bracket_error_next;
  logic          operator_error;
  logic          operator_error_next;
  logic          char_error;
  logic          char_error_next;
  kind_t         prev_kind;
  kind_t         prev_kind_next;
  logic          multi;
  logic          multi_next;

  logic          out_valid_next;
  bracket_code_t res_bracket;
  logic          res_operator;
  logic          res_char;

  assign s_go     = s_valid && (!s_last || !out_valid || !out_stall);
  assign in_stall = s_valid && !s_go;

  always_comb begin
    s_valid_next = s_valid;
    if (in_valid && !in_stall) begin
      s_valid_next = 1'b1;
    end else if (s_go) begin
      s_valid_next = 1'b0;
    end
  end

  always_comb begin
    depth_next          = depth;
    bracket_error_next  = bracket_error;
    operator_error_next = operator_error;
    char_error_next     = char_error;
    prev_kind_next      = prev_kind;
    multi_next          = multi;
    res_bracket         = BR_OK;
    res_operator        = 1'b0;
    res_char            = 1'b0;
    out_valid_next      = out_valid && out_stall;

    if (s_go && !(ignore_spaces && s_ch == CH_SPACE)) begin
      if (s_ch == CH_OPEN && bracket_error == BR_OK) begin
        if (&depth) begin
          bracket_error_next = BR_OVERFLOW;
        end else begin
          depth_next = depth + depth_t'(1);
        end
      end else if (s_ch == CH_CLOSE && bracket_error == BR_OK) begin
        if (depth == '0) begin
          bracket_error_next = BR_EARLY;
        end else begin
          depth_next = depth - depth_t'(1);
        end
      end
      if (!char_is_valid(s_ch)) begin
        char_error_next = 1'b1;
      end
      if (prev_kind == KIND_NONE) begin
        if (char_is_op(s_ch)) begin
          operator_error_next = 1'b1;
        end
      end else begin
        multi_next = 1'b1;
        if ((prev_kind == KIND_OP || prev_kind == KIND_OPEN) &&
            (char_is_op(s_ch) || s_ch == CH_CLOSE)) begin
          operator_error_next = 1'b1;
        end
      end
      if (char_is_op(s_ch)) begin
        prev_kind_next = KIND_OP;
      end else if (s_ch == CH_OPEN) begin
        prev_kind_next = KIND_OPEN;
      end else begin
        prev_kind_next = KIND_OTHER;
      end
    end

    if (bracket_error_next != BR_OK) begin
      res_bracket = bracket_error_next;
    end else if (depth_next != '0) begin
      res_bracket = BR_MISMATCH;
    end
    res_operator = multi_next && (operator_error_next || prev_kind_next == KIND_OP);
    res_char     = char_error_next;

    if (s_go && s_last) begin
      out_valid_next      = 1'b1;
      depth_next          = '0;
      bracket_error_next  = BR_OK;
      operator_error_next = 1'b0;
      char_error_next     = 1'b0;
      prev_kind_next      = KIND_NONE;
      multi_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_spaces  <= 1'b0;
      s_valid        <= 1'b0;
      out_valid      <= 1'b0;
      depth          <= '0;
      bracket_error  <= BR_OK;
      operator_error <= 1'b0;
      char_error     <= 1'b0;
      prev_kind      <= KIND_NONE;
      multi          <= 1'b0;
    end else begin
      if (cfg_write) begin
        ignore_spaces <= cfg_data;
      end
      s_valid        <= s_valid_next;
      out_valid      <= out_valid_next;
      depth          <= depth_next;
      bracket_error  <= bracket_error_next;
      operator_error <= operator_error_next;
      char_error     <= char_error_next;
      prev_kind      <= prev_kind_next;
      multi          <= multi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_ch   <= ch;
      s_last <= last;
    end
    if (s_go && s_last) begin
      bracket_status  <= res_bracket;
      operator_status <= res_operator;
      char_status     <= res_char;
    end
  end

endmodule

// File: design/iec_checker.sv
// Port checker for the infix expression checker, bound to the top level.
module iec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] bracket_status,
  input logic       operator_status,
  input logic       char_status
);

  // A stalled result keeps its verdicts.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bracket_status) &&
      $stable(operator_status) && $stable(char_status))
    else $error("stalled result changed");

  // The input side waits only behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A fresh result follows the transfer of a final character through the input register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
    else $error("result without a final character");

  // Reset leaves no result pending.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind infix_expression_checker iec_checker u_iec_checker (.*);
